>>> src/rsv_pkg.sv
`timescale 1ns / 1ps

package rsv_pkg;

  // field widths fixed by the interface
  localparam int CFG_W      = 6;
  localparam int SEQ_W      = 32;
  localparam int IN_TAG_W   = 9;
  localparam int BCAST_W    = 8;
  localparam int OUT_SLOT_W = 5;

  localparam logic [CFG_W-1:0] ACTIVE_RESET = 6'd32;

  typedef enum logic [1:0] {
    OP_INSERT   = 2'd0,
    OP_REMOVE   = 2'd1,
    OP_WAKEUP   = 2'd2,
    OP_SCHEDULE = 2'd3
  } rsv_op_t;

  // token handed from cell to cell while an item walks the table
  typedef struct packed {
    logic live;
    logic hit;
    logic free;
  } rsv_token_t;

endpackage

>>> src/rsv_cell.sv
`timescale 1ns / 1ps

module rsv_cell #(
  parameter int INDEX    = 0,
  parameter int TAG_BITS = 9,
  parameter int SLOT_W   = 5
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [rsv_pkg::CFG_W-1:0]  active_cnt,
  input  rsv_pkg::rsv_op_t           cmd_op,
  input  logic [rsv_pkg::SEQ_W-1:0]  cmd_seq,
  input  logic [TAG_BITS-1:0]        cmd_tag1,
  input  logic                       cmd_rdy1,
  input  logic [TAG_BITS-1:0]        cmd_tag2,
  input  logic                       cmd_rdy2,
  input  logic [TAG_BITS-1:0]        cmd_bcast,
  input  rsv_pkg::rsv_token_t        tok_in,
  input  logic [SLOT_W-1:0]          slot_in,
  output rsv_pkg::rsv_token_t        tok_out,
  output logic [SLOT_W-1:0]          slot_out
);
  import rsv_pkg::*;

  logic                valid_r, valid_nxt;
  logic                sched_r, sched_nxt;
  logic [SEQ_W-1:0]    seq_r, seq_nxt;
  logic [TAG_BITS-1:0] tag1_r, tag1_nxt;
  logic                rdy1_r, rdy1_nxt;
  logic [TAG_BITS-1:0] tag2_r, tag2_nxt;
  logic                rdy2_r, rdy2_nxt;
  rsv_token_t          tok_r, tok_nxt;
  logic [SLOT_W-1:0]   slot_r, slot_nxt;

  logic in_range;
  logic act;
  logic seq_match;
  logic tag1_match;
  logic tag2_match;
  logic matched;
  logic take;

  assign in_range   = (32'(INDEX) < 32'(active_cnt));
  assign act        = tok_in.live && in_range;
  assign seq_match  = valid_r && (seq_r == cmd_seq);
  assign tag1_match = valid_r && (tag1_r == cmd_bcast);
  assign tag2_match = valid_r && (tag2_r == cmd_bcast);

  always_comb begin
    valid_nxt = valid_r;
    sched_nxt = sched_r;
    seq_nxt   = seq_r;
    tag1_nxt  = tag1_r;
    rdy1_nxt  = rdy1_r;
    tag2_nxt  = tag2_r;
    rdy2_nxt  = rdy2_r;
    matched   = 1'b0;
    take      = 1'b0;

    if (act) begin
      case (cmd_op)
        OP_INSERT: begin
          matched = !valid_r;
          take    = matched && !tok_in.hit;
          if (take) begin
            valid_nxt = 1'b1;
            sched_nxt = 1'b0;
            seq_nxt   = cmd_seq;
            tag1_nxt  = cmd_tag1;
            rdy1_nxt  = cmd_rdy1;
            tag2_nxt  = cmd_tag2;
            rdy2_nxt  = cmd_rdy2;
          end
        end
        OP_REMOVE: begin
          matched = seq_match && sched_r;
          take    = matched && !tok_in.hit;
          if (take) begin
            valid_nxt = 1'b0;
            sched_nxt = 1'b0;
          end
        end
        OP_WAKEUP: begin
          // every matching source wakes, only the first slot is reported
          matched = tag1_match || tag2_match;
          take    = matched && !tok_in.hit;
          if (tag1_match) rdy1_nxt = 1'b1;
          if (tag2_match) rdy2_nxt = 1'b1;
        end
        OP_SCHEDULE: begin
          matched = seq_match;
          take    = matched && !tok_in.hit;
          if (take) sched_nxt = 1'b1;
        end
        default: begin
          matched = 1'b0;
          take    = 1'b0;
        end
      endcase
    end

    tok_nxt.live = tok_in.live;
    tok_nxt.hit  = tok_in.hit || matched;
    tok_nxt.free = tok_in.free || (in_range && !valid_nxt);
    slot_nxt     = take ? SLOT_W'(INDEX) : slot_in;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      sched_r <= 1'b0;
      tok_r   <= '0;
    end else begin
      valid_r <= valid_nxt;
      sched_r <= sched_nxt;
      tok_r   <= tok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    seq_r  <= seq_nxt;
    tag1_r <= tag1_nxt;
    rdy1_r <= rdy1_nxt;
    tag2_r <= tag2_nxt;
    rdy2_r <= rdy2_nxt;
    slot_r <= slot_nxt;
  end

  assign tok_out  = tok_r;
  assign slot_out = slot_r;

endmodule

>>> src/reservation_station_table.sv
`timescale 1ns / 1ps

// reservation station table, built as a chain of slot cells
//
// input channel: an item (operation, sequence number, source tags and ready
// bits, broadcast tag) is taken at a clock edge where start is high and busy
// is low. busy stays high while the item walks the chain.
// result channel: out_strobe is high for exactly one cycle with out_op_hit,
// out_slot_index and out_has_space. the receiver cannot stall; the result is
// shown whether or not anyone looks.
// config: cfg_we writes cfg_wdata into the active slot count. write it only
// while busy is low and no result is pending.
// timing: after the item is taken, one token visits one cell per cycle, so
// the result appears once the token has left the last cell. busy drops in
// the cycle the result is shown, so a new item can be taken then: one item
// at a time, the next only after the last has walked the whole cell chain.
// reset: valid and scheduled bits clear, no token is in flight, the active
// count returns to 32. other slot contents are don't-care until written.
module reservation_station_table #(
  parameter int MAX_ENTRIES = 32,
  parameter int TAG_BITS    = 9
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // configuration
  input  logic                              cfg_we,
  input  logic [rsv_pkg::CFG_W-1:0]         cfg_wdata,
  // input items
  input  logic                              start,
  output logic                              busy,
  input  logic [1:0]                        in_operation,
  input  logic [rsv_pkg::SEQ_W-1:0]         in_inst_number,
  input  logic signed [rsv_pkg::IN_TAG_W-1:0] in_first_source_tag,
  input  logic                              in_first_source_ready,
  input  logic signed [rsv_pkg::IN_TAG_W-1:0] in_second_source_tag,
  input  logic                              in_second_source_ready,
  input  logic [rsv_pkg::BCAST_W-1:0]       in_broadcast_tag,
  // results
  output logic                              out_strobe,
  output logic                              out_op_hit,
  output logic [rsv_pkg::OUT_SLOT_W-1:0]    out_slot_index,
  output logic                              out_has_space
);
  import rsv_pkg::*;

  localparam int SLOT_W  = $clog2(MAX_ENTRIES);
  localparam int TW_IN   = (TAG_BITS > IN_TAG_W) ? TAG_BITS : IN_TAG_W;
  localparam int TW_BC   = (TAG_BITS > BCAST_W) ? TAG_BITS : BCAST_W;
  localparam int SW_OUT  = (SLOT_W > OUT_SLOT_W) ? SLOT_W : OUT_SLOT_W;

  // active slot count
  logic [CFG_W-1:0] cfg_active_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_active_r <= ACTIVE_RESET;
    end else if (cfg_we) begin
      cfg_active_r <= cfg_wdata;
    end
  end

  // handshake and token launch
  logic accept;
  logic busy_r;
  logic launch_r;

  assign accept = start && !busy_r;
  assign busy   = busy_r;

  // token chain: entry k feeds cell k, the last entry is the finished result
  rsv_token_t        tok_chain  [0:MAX_ENTRIES];
  logic [SLOT_W-1:0] slot_chain [0:MAX_ENTRIES];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b0;
      launch_r <= 1'b0;
    end else begin
      launch_r <= accept;
      if (accept) begin
        busy_r <= 1'b1;
      end else if (tok_chain[MAX_ENTRIES-1].live) begin
        // last cell works this cycle, result shows next cycle
        busy_r <= 1'b0;
      end
    end
  end

  // item held for the whole walk, tags brought to stored width
  rsv_op_t           cmd_op_r;
  logic [SEQ_W-1:0]  cmd_seq_r;
  logic [TAG_BITS-1:0] cmd_tag1_r;
  logic              cmd_rdy1_r;
  logic [TAG_BITS-1:0] cmd_tag2_r;
  logic              cmd_rdy2_r;
  logic [TAG_BITS-1:0] cmd_bcast_r;

  logic [TW_IN-1:0]  tag1_wide;
  logic [TW_IN-1:0]  tag2_wide;
  logic [TW_BC-1:0]  bcast_wide;

  // tags are kept as raw bit patterns, so a no-dependency tag never matches
  assign tag1_wide  = TW_IN'($unsigned(in_first_source_tag));
  assign tag2_wide  = TW_IN'($unsigned(in_second_source_tag));
  assign bcast_wide = TW_BC'(in_broadcast_tag);

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_op_r    <= rsv_op_t'(in_operation);
      cmd_seq_r   <= in_inst_number;
      cmd_tag1_r  <= tag1_wide[TAG_BITS-1:0];
      cmd_rdy1_r  <= in_first_source_ready;
      cmd_tag2_r  <= tag2_wide[TAG_BITS-1:0];
      cmd_rdy2_r  <= in_second_source_ready;
      cmd_bcast_r <= bcast_wide[TAG_BITS-1:0];
    end
  end

  // fresh token: nothing found yet, no free slot seen yet
  assign tok_chain[0].live = launch_r;
  assign tok_chain[0].hit  = 1'b0;
  assign tok_chain[0].free = 1'b0;
  assign slot_chain[0]     = '0;

  for (genvar k = 0; k < MAX_ENTRIES; k++) begin : g_cell
    rsv_cell #(
      .INDEX    (k),
      .TAG_BITS (TAG_BITS),
      .SLOT_W   (SLOT_W)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .active_cnt (cfg_active_r),
      .cmd_op     (cmd_op_r),
      .cmd_seq    (cmd_seq_r),
      .cmd_tag1   (cmd_tag1_r),
      .cmd_rdy1   (cmd_rdy1_r),
      .cmd_tag2   (cmd_tag2_r),
      .cmd_rdy2   (cmd_rdy2_r),
      .cmd_bcast  (cmd_bcast_r),
      .tok_in     (tok_chain[k]),
      .slot_in    (slot_chain[k]),
      .tok_out    (tok_chain[k+1]),
      .slot_out   (slot_chain[k+1])
    );
  end

  // result straight from the last cell's registers
  logic [SW_OUT-1:0] slot_wide;

  assign slot_wide      = SW_OUT'(slot_chain[MAX_ENTRIES]);
  assign out_strobe     = tok_chain[MAX_ENTRIES].live;
  assign out_op_hit     = tok_chain[MAX_ENTRIES].hit;
  assign out_has_space  = tok_chain[MAX_ENTRIES].free;
  assign out_slot_index = slot_wide[OUT_SLOT_W-1:0];

  // token positions, for the checks below
  logic [MAX_ENTRIES:0] live_vec;

  for (genvar k = 0; k <= MAX_ENTRIES; k++) begin : g_live
    assign live_vec[k] = tok_chain[k].live;
  end

  // at most one item walks the chain
  a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(live_vec))
    else $error("more than one token in the cell chain");

  // no token in flight while idle, except the finished one being shown
  a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !busy_r |-> (live_vec[MAX_ENTRIES-1:0] == '0))
    else $error("token in flight while not busy");

  // every taken item gives its result after the full chain walk
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##(MAX_ENTRIES + 1) out_strobe)
    else $error("result missing after chain walk");

  // a miss reports slot zero
  a_miss_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_op_hit) |-> (out_slot_index == '0))
    else $error("nonzero slot on a miss");

endmodule

>>> bench/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import rsv_pkg::*;

  localparam int MAX_ENTRIES    = 32;
  localparam int LATENCY        = MAX_ENTRIES + 1;  // launch register plus one cell per cycle
  localparam int WATCHDOG_LIMIT = 2000;             // idle cycles before giving up
  localparam int NUM_PHASES     = 9;
  localparam int MAX_REPORTS    = 10;

  // one item as presented on the input ports
  typedef struct {
    rsv_op_t                    op;
    logic [SEQ_W-1:0]           inst;
    logic signed [IN_TAG_W-1:0] tag1;
    logic                       rdy1;
    logic signed [IN_TAG_W-1:0] tag2;
    logic                       rdy2;
    logic [BCAST_W-1:0]         bcast;
  } rs_item_t;

  // one result as seen on the output ports
  typedef struct {
    logic                  hit;
    logic [OUT_SLOT_W-1:0] slot;
    logic                  space;
  } rs_result_t;

  // mirror of the station table plus the queue of pending results
  class rs_scoreboard;
    logic [CFG_W-1:0]    active;
    bit                  valid [MAX_ENTRIES];
    bit                  sched [MAX_ENTRIES];
    logic [SEQ_W-1:0]    seq   [MAX_ENTRIES];
    logic [IN_TAG_W-1:0] tag1  [MAX_ENTRIES];
    logic [IN_TAG_W-1:0] tag2  [MAX_ENTRIES];
    bit                  rdy1  [MAX_ENTRIES];
    bit                  rdy2  [MAX_ENTRIES];
    rs_result_t          expected_q [$];
    int                  errors;
    int                  checked;
    int                  hits [4];
    int                  full_drops;

    function new();
      active = ACTIVE_RESET;
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        valid[i] = 0;
        sched[i] = 0;
      end
      errors = 0;
      checked = 0;
      full_drops = 0;
      for (int i = 0; i < 4; i++) hits[i] = 0;
    endfunction

    function void set_active(logic [CFG_W-1:0] v);
      active = v;
    endfunction

    function int live_slots();
      return (active > MAX_ENTRIES) ? MAX_ENTRIES : int'(active);
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // apply one accepted item to the mirror and queue its result
    function void note_item(rs_item_t it);
      rs_result_t r;
      int n;
      bit m;
      n = live_slots();
      r.hit = 0;
      r.slot = '0;
      case (it.op)
        OP_INSERT: begin
          for (int i = 0; i < n; i++) begin
            if (!valid[i]) begin
              valid[i] = 1;
              sched[i] = 0;
              seq[i]   = it.inst;
              tag1[i]  = it.tag1;
              rdy1[i]  = it.rdy1;
              tag2[i]  = it.tag2;
              rdy2[i]  = it.rdy2;
              r.hit    = 1;
              r.slot   = i[OUT_SLOT_W-1:0];
              break;
            end
          end
          if (!r.hit && n > 0) full_drops++;
        end
        OP_REMOVE: begin
          for (int i = 0; i < n; i++) begin
            if (valid[i] && sched[i] && seq[i] == it.inst) begin
              valid[i] = 0;
              sched[i] = 0;
              r.hit    = 1;
              r.slot   = i[OUT_SLOT_W-1:0];
              break;
            end
          end
        end
        OP_WAKEUP: begin
          for (int i = 0; i < n; i++) begin
            m = 0;
            if (valid[i]) begin
              if (tag1[i] == {1'b0, it.bcast}) begin
                rdy1[i] = 1;
                m = 1;
              end
              if (tag2[i] == {1'b0, it.bcast}) begin
                rdy2[i] = 1;
                m = 1;
              end
              if (m && !r.hit) begin
                r.hit  = 1;
                r.slot = i[OUT_SLOT_W-1:0];
              end
            end
          end
        end
        default: begin
          for (int i = 0; i < n; i++) begin
            if (valid[i] && seq[i] == it.inst) begin
              sched[i] = 1;
              r.hit    = 1;
              r.slot   = i[OUT_SLOT_W-1:0];
              break;
            end
          end
        end
      endcase
      r.space = 0;
      for (int i = 0; i < n; i++)
        if (!valid[i]) r.space = 1;
      if (r.hit) hits[it.op]++;
      expected_q.push_back(r);
    endfunction

    function void check_result(rs_result_t got);
      rs_result_t want;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("ERROR %0t: result with nothing pending: hit=%0d slot=%0d space=%0d",
                   $realtime, got.hit, got.slot, got.space);
        return;
      end
      want = expected_q.pop_front();
      checked++;
      if (got.hit !== want.hit || got.slot !== want.slot || got.space !== want.space) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("ERROR %0t: hit exp %0d got %0d, slot exp %0d got %0d, space exp %0d got %0d",
                   $realtime, want.hit, got.hit, want.slot, got.slot, want.space, got.space);
      end
    endfunction
  endclass

  // clock and reset
  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // block inputs, all known from time zero
  logic                       cfg_we                 = 1'b0;
  logic [CFG_W-1:0]           cfg_wdata              = '0;
  logic                       start                  = 1'b0;
  logic [1:0]                 in_operation           = '0;
  logic [SEQ_W-1:0]           in_inst_number         = '0;
  logic signed [IN_TAG_W-1:0] in_first_source_tag    = '0;
  logic                       in_first_source_ready  = 1'b0;
  logic signed [IN_TAG_W-1:0] in_second_source_tag   = '0;
  logic                       in_second_source_ready = 1'b0;
  logic [BCAST_W-1:0]         in_broadcast_tag       = '0;

  logic                  busy;
  logic                  out_strobe;
  logic                  out_op_hit;
  logic [OUT_SLOT_W-1:0] out_slot_index;
  logic                  out_has_space;

  reservation_station_table #(
    .MAX_ENTRIES(MAX_ENTRIES),
    .TAG_BITS   (IN_TAG_W)
  ) dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cfg_we                (cfg_we),
    .cfg_wdata             (cfg_wdata),
    .start                 (start),
    .busy                  (busy),
    .in_operation          (in_operation),
    .in_inst_number        (in_inst_number),
    .in_first_source_tag   (in_first_source_tag),
    .in_first_source_ready (in_first_source_ready),
    .in_second_source_tag  (in_second_source_tag),
    .in_second_source_ready(in_second_source_ready),
    .in_broadcast_tag      (in_broadcast_tag),
    .out_strobe            (out_strobe),
    .out_op_hit            (out_op_hit),
    .out_slot_index        (out_slot_index),
    .out_has_space         (out_has_space)
  );

  rs_scoreboard sb = new();

  int items_sent  = 0;
  int cfg_writes  = 0;
  int idle_cycles = 0;

  // result side: every strobe is checked against the oldest prediction
  always @(posedge clk) begin
    rs_result_t got;
    if (rst_n && out_strobe) begin
      got.hit   = out_op_hit;
      got.slot  = out_slot_index;
      got.space = out_has_space;
      sb.check_result(got);
    end
  end

  // watchdog: counts cycles where neither an item nor a result moves
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_strobe) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("ERROR: no activity for %0d cycles, %0d results still pending",
                 WATCHDOG_LIMIT, sb.pending());
        $display("Verification failed");
        $finish;
      end
    end
  end

  function automatic rs_item_t make_item(rsv_op_t op, logic [SEQ_W-1:0] inst,
                                         int t1, logic r1,
                                         int t2, logic r2,
                                         logic [BCAST_W-1:0] bt);
    rs_item_t it;
    it.op    = op;
    it.inst  = inst;
    it.tag1  = IN_TAG_W'(t1);
    it.rdy1  = r1;
    it.tag2  = IN_TAG_W'(t2);
    it.rdy2  = r2;
    it.bcast = bt;
    return it;
  endfunction

  // sequence number with the extremes well represented
  function automatic logic [SEQ_W-1:0] random_seq();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return '0;
    if (r < 16) return '1;
    return $urandom;
  endfunction

  // sequence number of a live entry (scheduled ones only if asked), so that
  // remove and schedule mostly find something
  function automatic logic [SEQ_W-1:0] pick_seq(bit want_sched);
    int cand [$];
    for (int i = 0; i < MAX_ENTRIES; i++)
      if (sb.valid[i] && (!want_sched || sb.sched[i])) cand.push_back(i);
    if (cand.size() == 0 || $urandom_range(0, 99) < 15) return random_seq();
    return sb.seq[cand[$urandom_range(0, cand.size() - 1)]];
  endfunction

  // source tag for an insert: mostly a small set so wakeups collide
  function automatic logic signed [IN_TAG_W-1:0] random_tag();
    int r;
    r = $urandom_range(0, 99);
    if (r < 12) return IN_TAG_W'(-1);
    if (r < 70) return IN_TAG_W'($urandom_range(0, 15));
    return IN_TAG_W'($urandom_range(0, 255));
  endfunction

  // broadcast tag: usually one that some live entry waits on
  function automatic logic [BCAST_W-1:0] pick_bcast();
    logic [BCAST_W-1:0] cand [$];
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      if (sb.valid[i] && !sb.tag1[i][IN_TAG_W-1]) cand.push_back(sb.tag1[i][BCAST_W-1:0]);
      if (sb.valid[i] && !sb.tag2[i][IN_TAG_W-1]) cand.push_back(sb.tag2[i][BCAST_W-1:0]);
    end
    if (cand.size() == 0 || $urandom_range(0, 99) < 30)
      return ($urandom_range(0, 1) != 0) ? BCAST_W'($urandom_range(0, 15))
                                         : BCAST_W'($urandom_range(0, 255));
    return cand[$urandom_range(0, cand.size() - 1)];
  endfunction

  function automatic rs_item_t random_item();
    rs_item_t it;
    int r;
    it = make_item(OP_INSERT, random_seq(), int'(random_tag()), 1'($urandom_range(0, 1)),
                   int'(random_tag()), 1'($urandom_range(0, 1)),
                   BCAST_W'($urandom_range(0, 255)));
    r = $urandom_range(0, 99);
    if (r < 32) begin
      // duplicates of live sequence numbers now and then
      if ($urandom_range(0, 99) < 20) it.inst = pick_seq(1'b0);
    end else if (r < 55) begin
      it.op   = OP_SCHEDULE;
      it.inst = pick_seq(1'b0);
    end else if (r < 78) begin
      it.op   = OP_REMOVE;
      it.inst = pick_seq(1'b1);
    end else begin
      it.op    = OP_WAKEUP;
      it.bcast = pick_bcast();
    end
    return it;
  endfunction

  // gaps between items: runs with none, mostly short, a few long enough to
  // land anywhere around the point where busy drops
  function automatic int pick_gap(int idx);
    int r;
    if (idx % 100 < 30) return 0;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 80) return $urandom_range(1, 4);
    if (r < 95) return $urandom_range(5, 45);
    return $urandom_range(46, 120);
  endfunction

  // present one item and hold it until the block takes it
  task automatic send_item(rs_item_t it);
    in_operation           <= it.op;
    in_inst_number         <= it.inst;
    in_first_source_tag    <= it.tag1;
    in_first_source_ready  <= it.rdy1;
    in_second_source_tag   <= it.tag2;
    in_second_source_ready <= it.rdy2;
    in_broadcast_tag       <= it.bcast;
    start                  <= 1'b1;
    do @(posedge clk); while (busy);
    sb.note_item(it);
    items_sent++;
  endtask

  // after an item: either keep start high for the next one or idle a while
  task automatic idle_after(int idx, bit last);
    int gap;
    gap = last ? 1 : pick_gap(idx);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // the count is only changed once every pending result has come back
  task automatic write_active(logic [CFG_W-1:0] v);
    while (sb.pending() != 0) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    sb.set_active(v);
    cfg_writes++;
  endtask

  initial begin
    rs_item_t directed [$];
    int phase_cfg [NUM_PHASES];
    int phase_len [NUM_PHASES];

    // table sizes walked by the random part: saturating, tiny, empty, full
    // size, and shrink/grow in between so hidden slots come back into view
    phase_cfg = '{63, 1, 0, 3, 32, 7, 33, 16, 2};
    phase_len = '{250, 60, 20, 150, 300, 150, 100, 150, 120};
    phase_cfg[8] = $urandom_range(2, 30);

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part on a two-slot table
    write_active(6'd2);
    directed.push_back(make_item(OP_INSERT, 32'h0000_0000, -1, 1'b0, 255, 1'b1, 8'd0));
    directed.push_back(make_item(OP_INSERT, 32'hFFFF_FFFF, 0, 1'b1, -1, 1'b0, 8'd0));
    // table full: dropped, no space left
    directed.push_back(make_item(OP_INSERT, 32'h0000_0005, 3, 1'b0, 4, 1'b0, 8'd0));
    directed.push_back(make_item(OP_WAKEUP, 32'h0, 0, 1'b0, 0, 1'b0, 8'd255));
    // source already ready still matches
    directed.push_back(make_item(OP_WAKEUP, 32'h0, 0, 1'b0, 0, 1'b0, 8'd255));
    directed.push_back(make_item(OP_WAKEUP, 32'h0, 0, 1'b0, 0, 1'b0, 8'd0));
    directed.push_back(make_item(OP_WAKEUP, 32'h0, 0, 1'b0, 0, 1'b0, 8'd1));
    // remove before schedule misses
    directed.push_back(make_item(OP_REMOVE, 32'hFFFF_FFFF, 0, 1'b0, 0, 1'b0, 8'd0));
    directed.push_back(make_item(OP_SCHEDULE, 32'hFFFF_FFFF, 0, 1'b0, 0, 1'b0, 8'd0));
    directed.push_back(make_item(OP_SCHEDULE, 32'h0000_004D, 0, 1'b0, 0, 1'b0, 8'd0));
    directed.push_back(make_item(OP_REMOVE, 32'hFFFF_FFFF, 0, 1'b0, 0, 1'b0, 8'd0));
    directed.push_back(make_item(OP_SCHEDULE, 32'h0000_0000, 0, 1'b0, 0, 1'b0, 8'd0));
    directed.push_back(make_item(OP_REMOVE, 32'h0000_0000, 0, 1'b0, 0, 1'b0, 8'd0));
    // duplicate sequence numbers: the lowest slot wins
    directed.push_back(make_item(OP_INSERT, 32'h5555_5555, 170, 1'b0, 85, 1'b0, 8'd0));
    directed.push_back(make_item(OP_INSERT, 32'h5555_5555, 85, 1'b0, 170, 1'b0, 8'd0));
    directed.push_back(make_item(OP_WAKEUP, 32'h0, 0, 1'b0, 0, 1'b0, 8'd85));
    directed.push_back(make_item(OP_SCHEDULE, 32'h5555_5555, 0, 1'b0, 0, 1'b0, 8'd0));
    directed.push_back(make_item(OP_REMOVE, 32'h5555_5555, 0, 1'b0, 0, 1'b0, 8'd0));
    directed.push_back(make_item(OP_REMOVE, 32'h5555_5555, 0, 1'b0, 0, 1'b0, 8'd0));
    directed.push_back(make_item(OP_SCHEDULE, 32'h5555_5555, 0, 1'b0, 0, 1'b0, 8'd0));
    directed.push_back(make_item(OP_REMOVE, 32'h5555_5555, 0, 1'b0, 0, 1'b0, 8'd0));
    foreach (directed[i]) begin
      send_item(directed[i]);
      idle_after(i, i == directed.size() - 1);
    end

    // random part, one table size per phase
    for (int p = 0; p < NUM_PHASES; p++) begin
      write_active(CFG_W'(phase_cfg[p]));
      for (int i = 0; i < phase_len[p]; i++) begin
        send_item(random_item());
        idle_after(i, i == phase_len[p] - 1);
      end
    end

    // drain, then watch a little longer for stray strobes
    while (sb.pending() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);

    $display("%0d items over %0d table sizes, %0d results checked, %0d mismatches",
             items_sent, cfg_writes, sb.checked, sb.errors);
    $display("hits: insert %0d remove %0d wakeup %0d schedule %0d; full-table drops %0d",
             sb.hits[OP_INSERT], sb.hits[OP_REMOVE], sb.hits[OP_WAKEUP],
             sb.hits[OP_SCHEDULE], sb.full_drops);
    if (sb.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

>>> sim.f
src/rsv_pkg.sv
src/rsv_cell.sv
src/reservation_station_table.sv
bench/testbench.sv
